@@ rtl/fingerprint_enroll_sequencer_macros.svh @@
// Assertion macros shared by the enrollment sequencer modules.
`ifndef FINGERPRINT_ENROLL_SEQUENCER_MACROS_SVH
`define FINGERPRINT_ENROLL_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fingerprint enroll sequencer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fingerprint enroll sequencer: assertion failed");

`endif

@@ rtl/fes_pkg.sv @@
package fes_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUT_FINGER_TIMEOUT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMOVE_FINGER_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_TIMEOUT         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENROLL_CAPTURES       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUPLICATE_CHECK       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIBRARY_PAGES         = 3'd6;

    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_PUT_FINGER_TIMEOUT    = 16'd100;
    localparam logic [15:0] RST_REMOVE_FINGER_TIMEOUT = 16'd100;
    localparam logic [15:0] RST_REPLY_TIMEOUT         = 16'd50;
    localparam logic [3:0]  RST_ENROLL_CAPTURES       = 4'd4;
    localparam logic [3:0]  RST_RETRY_LIMIT           = 4'd3;
    localparam logic        RST_DUPLICATE_CHECK       = 1'b1;
    localparam logic [15:0] RST_LIBRARY_PAGES         = 16'd100;

    // Reply classes from the fingerprint module
    localparam logic [2:0] CLS_OK           = 3'd0;
    localparam logic [2:0] CLS_CAPTURE_FAIL = 3'd1;
    localparam logic [2:0] CLS_NO_FINGER    = 3'd2;
    localparam logic [2:0] CLS_BAD_IMAGE    = 3'd3;
    localparam logic [2:0] CLS_FEATURE_FAIL = 3'd4;
    localparam logic [2:0] CLS_NOT_FOUND    = 3'd5;

    // Module commands
    localparam logic [2:0] MCMD_NONE    = 3'd0;
    localparam logic [2:0] MCMD_CAPTURE = 3'd1;
    localparam logic [2:0] MCMD_GEN     = 3'd2;
    localparam logic [2:0] MCMD_SEARCH  = 3'd3;
    localparam logic [2:0] MCMD_MERGE   = 3'd4;
    localparam logic [2:0] MCMD_STORE   = 3'd5;

    // Voice prompts
    localparam logic [1:0] PROMPT_NONE  = 2'd0;
    localparam logic [1:0] PROMPT_PLACE = 2'd1;
    localparam logic [1:0] PROMPT_AGAIN = 2'd2;

    // Reported outcome
    localparam logic [1:0] OUT_BUSY     = 2'd0;
    localparam logic [1:0] OUT_ENROLLED = 2'd1;
    localparam logic [1:0] OUT_FAILED   = 2'd2;

    // Failure causes
    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT   = 2'd1;
    localparam logic [1:0] CAUSE_ENROLL    = 2'd2;
    localparam logic [1:0] CAUSE_DUPLICATE = 2'd3;

    localparam logic CMD_POLL    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        reply_seen;
        logic [2:0]  reply_class;
        logic [15:0] user_slot;
    } fes_in_t;

    typedef struct packed {
        logic [2:0]  module_cmd;
        logic [15:0] cmd_arg;
        logic [1:0]  prompt;
        logic        wake;
        logic [1:0]  phase;
        logic [1:0]  fail_cause;
    } fes_out_t;

    typedef struct packed {
        logic [15:0] put_finger_timeout;
        logic [15:0] remove_finger_timeout;
        logic [15:0] reply_timeout;
        logic [3:0]  enroll_captures;
        logic [3:0]  retry_limit;
        logic        duplicate_check;
        logic [15:0] library_pages;
    } fes_cfg_t;

endpackage

@@ rtl/fes_cfg_regs.sv @@
module fes_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fes_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fes_pkg::CFG_DATA_W-1:0]      cfg_data,
    output fes_pkg::fes_cfg_t                   cfg
);
    import fes_pkg::*;

    fes_cfg_t cfg_reg;

    // Writes never stall.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.put_finger_timeout    <= RST_PUT_FINGER_TIMEOUT;
            cfg_reg.remove_finger_timeout <= RST_REMOVE_FINGER_TIMEOUT;
            cfg_reg.reply_timeout         <= RST_REPLY_TIMEOUT;
            cfg_reg.enroll_captures       <= RST_ENROLL_CAPTURES;
            cfg_reg.retry_limit           <= RST_RETRY_LIMIT;
            cfg_reg.duplicate_check       <= RST_DUPLICATE_CHECK;
            cfg_reg.library_pages         <= RST_LIBRARY_PAGES;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PUT_FINGER_TIMEOUT:    cfg_reg.put_finger_timeout    <= cfg_data;
                CFG_REMOVE_FINGER_TIMEOUT: cfg_reg.remove_finger_timeout <= cfg_data;
                CFG_REPLY_TIMEOUT:         cfg_reg.reply_timeout         <= cfg_data;
                CFG_ENROLL_CAPTURES:       cfg_reg.enroll_captures       <= cfg_data[3:0];
                CFG_RETRY_LIMIT:           cfg_reg.retry_limit           <= cfg_data[3:0];
                CFG_DUPLICATE_CHECK:       cfg_reg.duplicate_check       <= cfg_data[0];
                CFG_LIBRARY_PAGES:         cfg_reg.library_pages         <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/fes_seq_core.sv @@
`include "fingerprint_enroll_sequencer_macros.svh"

module fes_seq_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  fes_pkg::fes_in_t  item,
    input  fes_pkg::fes_cfg_t cfg,
    output fes_pkg::fes_out_t result
);
    import fes_pkg::*;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_SEND_IMG    = 4'd1,
        PH_WAIT_IMG    = 4'd2,
        PH_SEND_GEN    = 4'd3,
        PH_WAIT_GEN    = 4'd4,
        PH_SEND_SEARCH = 4'd5,
        PH_WAIT_SEARCH = 4'd6,
        PH_SEND_LIFT   = 4'd7,
        PH_WAIT_LIFT   = 4'd8,
        PH_SEND_MERGE  = 4'd9,
        PH_WAIT_MERGE  = 4'd10,
        PH_SEND_STORE  = 4'd11,
        PH_WAIT_STORE  = 4'd12,
        PH_DONE        = 4'd13,
        PH_FAILED      = 4'd14
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [3:0]  captures_done_reg, captures_done_next;
    logic [3:0]  failures_seen_reg, failures_seen_next;
    logic        dup_pending_reg, dup_pending_next;
    logic [1:0]  cause_held_reg, cause_held_next;

    logic [15:0] wc_dec1, wc_dec2;
    logic        dec1_zero, dec2_zero;
    logic [3:0]  captures_bump, failures_bump;

    // Saturating countdowns
    assign wc_dec1   = (wait_count_reg != 16'd0) ? (wait_count_reg - 16'd1) : 16'd0;
    assign wc_dec2   = (wait_count_reg > 16'd2) ? (wait_count_reg - 16'd2) : 16'd0;
    assign dec1_zero = (wc_dec1 == 16'd0);
    assign dec2_zero = (wc_dec2 == 16'd0);

    assign captures_bump = (captures_done_reg != 4'hF) ? (captures_done_reg + 4'd1)
                                                       : captures_done_reg;
    assign failures_bump = (failures_seen_reg != 4'hF) ? (failures_seen_reg + 4'd1)
                                                       : failures_seen_reg;

    always_comb begin
        phase_cur          = (item.cmd == CMD_RESTART) ? PH_START : phase_reg;
        phase_next         = phase_cur;
        wait_count_next    = wait_count_reg;
        captures_done_next = captures_done_reg;
        failures_seen_next = failures_seen_reg;
        dup_pending_next   = dup_pending_reg;
        cause_held_next    = (item.cmd == CMD_RESTART) ? CAUSE_NONE : cause_held_reg;
        result             = '0;

        case (phase_cur)
            PH_START: begin
                phase_next         = PH_SEND_IMG;
                wait_count_next    = cfg.put_finger_timeout;
                captures_done_next = 4'd1;
                failures_seen_next = 4'd0;
                dup_pending_next   = cfg.duplicate_check;
                result.prompt      = PROMPT_PLACE;
            end
            PH_SEND_IMG: begin
                phase_next        = PH_WAIT_IMG;
                result.module_cmd = MCMD_CAPTURE;
            end
            PH_WAIT_IMG: begin
                if (item.reply_seen) begin
                    if (item.reply_class == CLS_OK) begin
                        phase_next  = PH_SEND_GEN;
                        result.wake = 1'b1;
                    end else if (item.reply_class == CLS_CAPTURE_FAIL ||
                                 item.reply_class == CLS_NO_FINGER ||
                                 item.reply_class == CLS_BAD_IMAGE) begin
                        phase_next = PH_SEND_IMG;
                        // No finger burns two polls of the placement budget.
                        if (item.reply_class == CLS_NO_FINGER) begin
                            wait_count_next = wc_dec2;
                            if (dec2_zero) begin
                                phase_next      = PH_FAILED;
                                cause_held_next = CAUSE_TIMEOUT;
                            end
                        end
                    end else begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_ENROLL;
                    end
                end else begin
                    wait_count_next = wc_dec1;
                    if (dec1_zero) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_TIMEOUT;
                    end
                end
            end
            PH_SEND_GEN: begin
                phase_next        = PH_WAIT_GEN;
                result.module_cmd = MCMD_GEN;
                result.cmd_arg    = {12'd0, captures_done_reg};
                wait_count_next   = cfg.reply_timeout;
            end
            PH_WAIT_GEN: begin
                if (item.reply_seen) begin
                    if (item.reply_class == CLS_OK) begin
                        if (captures_done_reg == 4'd1 && dup_pending_reg) begin
                            captures_done_next = captures_bump;
                            phase_next         = PH_SEND_SEARCH;
                            dup_pending_next   = 1'b0;
                            wait_count_next    = cfg.reply_timeout;
                        end else if (captures_done_reg < cfg.enroll_captures) begin
                            phase_next         = PH_SEND_LIFT;
                            wait_count_next    = cfg.remove_finger_timeout;
                            captures_done_next = captures_bump;
                            result.prompt      = PROMPT_AGAIN;
                        end else begin
                            phase_next      = PH_SEND_MERGE;
                            wait_count_next = cfg.reply_timeout;
                        end
                        result.wake = 1'b1;
                    end else if (item.reply_class == CLS_FEATURE_FAIL ||
                                 item.reply_class == CLS_CAPTURE_FAIL) begin
                        if (failures_seen_reg < cfg.retry_limit) begin
                            phase_next      = PH_SEND_LIFT;
                            wait_count_next = cfg.remove_finger_timeout;
                            result.wake     = 1'b1;
                            result.prompt   = PROMPT_AGAIN;
                        end else begin
                            phase_next      = PH_FAILED;
                            cause_held_next = CAUSE_ENROLL;
                        end
                        failures_seen_next = failures_bump;
                    end else begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_ENROLL;
                    end
                end else begin
                    wait_count_next = wc_dec1;
                    if (dec1_zero) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_TIMEOUT;
                    end
                end
            end
            PH_SEND_SEARCH: begin
                phase_next        = PH_WAIT_SEARCH;
                result.module_cmd = MCMD_SEARCH;
                result.cmd_arg    = cfg.library_pages;
            end
            PH_WAIT_SEARCH: begin
                if (item.reply_seen) begin
                    if (item.reply_class == CLS_OK) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_DUPLICATE;
                    end else if (item.reply_class == CLS_NOT_FOUND) begin
                        phase_next      = PH_SEND_LIFT;
                        wait_count_next = cfg.remove_finger_timeout;
                        result.wake     = 1'b1;
                        result.prompt   = PROMPT_AGAIN;
                    end else begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_ENROLL;
                    end
                end else begin
                    wait_count_next = wc_dec1;
                    if (dec1_zero) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_TIMEOUT;
                    end
                end
            end
            PH_SEND_LIFT: begin
                phase_next        = PH_WAIT_LIFT;
                result.module_cmd = MCMD_CAPTURE;
            end
            PH_WAIT_LIFT: begin
                if (item.reply_seen) begin
                    if (item.reply_class != CLS_NO_FINGER) begin
                        phase_next  = PH_SEND_LIFT;
                        result.wake = 1'b1;
                    end else begin
                        phase_next      = PH_SEND_IMG;
                        wait_count_next = cfg.put_finger_timeout;
                    end
                end else begin
                    wait_count_next = wc_dec1;
                    if (dec1_zero) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_TIMEOUT;
                    end
                end
            end
            PH_SEND_MERGE: begin
                phase_next        = PH_WAIT_MERGE;
                result.module_cmd = MCMD_MERGE;
                wait_count_next   = cfg.reply_timeout;
            end
            PH_WAIT_MERGE, PH_WAIT_STORE: begin
                if (item.reply_seen) begin
                    if (item.reply_class == CLS_OK) begin
                        phase_next = (phase_cur == PH_WAIT_MERGE) ? PH_SEND_STORE : PH_DONE;
                    end else begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_ENROLL;
                    end
                end else begin
                    wait_count_next = wc_dec1;
                    if (dec1_zero) begin
                        phase_next      = PH_FAILED;
                        cause_held_next = CAUSE_TIMEOUT;
                    end
                end
            end
            PH_SEND_STORE: begin
                phase_next        = PH_WAIT_STORE;
                result.module_cmd = MCMD_STORE;
                result.cmd_arg    = item.user_slot;
                wait_count_next   = cfg.reply_timeout;
            end
            default: ;
        endcase

        if (phase_next == PH_DONE) begin
            result.phase = OUT_ENROLLED;
        end else if (phase_next == PH_FAILED) begin
            result.phase      = OUT_FAILED;
            result.fail_cause = cause_held_next;
        end else begin
            result.phase = OUT_BUSY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_START;
            wait_count_reg    <= 16'd0;
            captures_done_reg <= 4'd1;
            failures_seen_reg <= 4'd0;
            dup_pending_reg   <= 1'b0;
            cause_held_reg    <= CAUSE_NONE;
        end else if (accept) begin
            phase_reg         <= phase_next;
            wait_count_reg    <= wait_count_next;
            captures_done_reg <= captures_done_next;
            failures_seen_reg <= failures_seen_next;
            dup_pending_reg   <= dup_pending_next;
            cause_held_reg    <= cause_held_next;
        end
    end

    `FES_ASSERT_IMPL(a_failed_has_cause, aclk, aresetn, phase_reg == PH_FAILED, cause_held_reg != CAUSE_NONE)
    `FES_ASSERT_IMPL(a_cmd_means_busy, aclk, aresetn, result.module_cmd != MCMD_NONE, result.phase == OUT_BUSY)
    `FES_ASSERT_IMPL(a_captures_nonzero, aclk, aresetn, 1'b1, captures_done_reg != 4'd0)

endmodule

@@ rtl/fingerprint_enroll_sequencer.sv @@
// Fingerprint enrollment sequencer: one poll in, one result out.
// Latency: a result is valid in the cycle after its poll transfer.
// Throughput: one poll per cycle while m_ready holds; the result register
// frees in the cycle its result transfers, so polls stream without gaps.
// Reset (aresetn low, synchronous): configuration returns to defaults, the
// sequencer returns to the start phase and the result register empties.
`include "fingerprint_enroll_sequencer_macros.svh"

module fingerprint_enroll_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // poll channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fes_pkg::fes_in_t                s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output fes_pkg::fes_out_t               m_data,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fes_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fes_pkg::*;

    fes_cfg_t cfg;
    fes_out_t result;
    fes_out_t m_data_reg;
    logic     m_valid_reg;
    logic     s_accept;

    // Take a poll whenever the result register is empty or being drained
    // this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    fes_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer state advances only on a poll transfer; its result is
    // combinational from the poll and the current state.
    fes_seq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .item    (s_data),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register: load on a poll transfer, drop when drained with no
    // new poll behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload holds without reset; load only on a poll transfer.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= result;
        end
    end

    `FES_ASSERT_NEXT(a_poll_yields_result, aclk, aresetn, s_accept, m_valid)
    `FES_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `FES_ASSERT_NEXT(a_drain_empties, aclk, aresetn, m_valid && m_ready && !s_valid, !m_valid)

endmodule

@@ tb/tb_fingerprint_enroll_sequencer.sv @@
module tb_fingerprint_enroll_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import fes_pkg::*;

    // Run guard: far above the slowest legal run (about 1200 polls, each at
    // worst a long sender gap plus a long result stall).
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    // Reply class and register index that the package leaves unnamed
    localparam logic [2:0] CLS_OTHER  = 3'd6;
    localparam logic [2:0] CLS_SEVEN  = 3'd7;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef enum logic [3:0] {
        SQ_START, SQ_SEND_IMG, SQ_WAIT_IMG, SQ_SEND_GEN, SQ_WAIT_GEN,
        SQ_SEND_SEARCH, SQ_WAIT_SEARCH, SQ_SEND_LIFT, SQ_WAIT_LIFT,
        SQ_SEND_MERGE, SQ_WAIT_MERGE, SQ_SEND_STORE, SQ_WAIT_STORE,
        SQ_DONE, SQ_FAILED
    } seq_phase_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    fes_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    fes_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fingerprint_enroll_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted copy of the sequencer: registers and state
    logic [15:0] cf_put, cf_lift, cf_reply, cf_pages;
    logic [3:0]  cf_caps, cf_retry;
    logic        cf_dup;
    seq_phase_e  st_phase;
    logic [15:0] st_wait;
    logic [3:0]  st_caps, st_fails;
    logic        st_dup;
    logic [1:0]  st_cause;

    // Poll reports predicted but not yet seen on the result channel
    fes_out_t poll_reports_due[$];
    fes_out_t due;

    int mismatches;
    int cycle_count;
    int snd_idle_pct;
    int rcv_idle_pct;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run; a missing result never drains the queue.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result channel at the current idle rate.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(name, {16'd0, got}, {16'd0, want});
    endtask

    // Compare every transferred result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (poll_reports_due.size() == 0) begin
                report_mismatch("result with no poll outstanding", 32'(m_data), 32'd0);
            end else begin
                due = poll_reports_due.pop_front();
                check_field("module_cmd", 16'(m_data.module_cmd), 16'(due.module_cmd));
                check_field("cmd_arg",    m_data.cmd_arg,         due.cmd_arg);
                check_field("prompt",     16'(m_data.prompt),     16'(due.prompt));
                check_field("wake",       16'(m_data.wake),       16'(due.wake));
                check_field("phase",      16'(m_data.phase),      16'(due.phase));
                check_field("fail_cause", 16'(m_data.fail_cause), 16'(due.fail_cause));
            end
        end
    end

    function automatic void reset_model();
        cf_put   = RST_PUT_FINGER_TIMEOUT;
        cf_lift  = RST_REMOVE_FINGER_TIMEOUT;
        cf_reply = RST_REPLY_TIMEOUT;
        cf_caps  = RST_ENROLL_CAPTURES;
        cf_retry = RST_RETRY_LIMIT;
        cf_dup   = RST_DUPLICATE_CHECK;
        cf_pages = RST_LIBRARY_PAGES;
        st_phase = SQ_START;
        st_wait  = 16'd0;
        st_caps  = 4'd1;
        st_fails = 4'd0;
        st_dup   = 1'b0;
        st_cause = CAUSE_NONE;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] d);
        case (idx)
            CFG_PUT_FINGER_TIMEOUT:    cf_put   = d;
            CFG_REMOVE_FINGER_TIMEOUT: cf_lift  = d;
            CFG_REPLY_TIMEOUT:         cf_reply = d;
            CFG_ENROLL_CAPTURES:       cf_caps  = d[3:0];
            CFG_RETRY_LIMIT:           cf_retry = d[3:0];
            CFG_DUPLICATE_CHECK:       cf_dup   = d[0];
            CFG_LIBRARY_PAGES:         cf_pages = d;
            default: ;
        endcase
    endfunction

    // Count down one poll, saturating; true once the count sits at zero.
    function automatic bit tick_wait();
        if (st_wait != 16'd0)
            st_wait--;
        return st_wait == 16'd0;
    endfunction

    function automatic void fail_enroll(logic [1:0] cause);
        st_phase = SQ_FAILED;
        st_cause = cause;
    endfunction

    // Advance the predicted sequencer by one poll and return its report.
    function automatic fes_out_t enroll_step(fes_in_t p);
        fes_out_t   r;
        logic [2:0] cls;
        r   = '0;
        cls = p.reply_class;
        if (p.cmd == CMD_RESTART) begin
            st_phase = SQ_START;
            st_cause = CAUSE_NONE;
        end
        case (st_phase)
            SQ_START: begin
                st_phase = SQ_SEND_IMG;
                st_wait  = cf_put;
                st_caps  = 4'd1;
                st_fails = 4'd0;
                st_dup   = cf_dup;
                r.prompt = PROMPT_PLACE;
            end
            SQ_SEND_IMG: begin
                st_phase     = SQ_WAIT_IMG;
                r.module_cmd = MCMD_CAPTURE;
            end
            SQ_WAIT_IMG: begin
                if (p.reply_seen) begin
                    if (cls == CLS_OK) begin
                        st_phase = SQ_SEND_GEN;
                        r.wake   = 1'b1;
                    end else if (cls == CLS_CAPTURE_FAIL || cls == CLS_NO_FINGER ||
                                 cls == CLS_BAD_IMAGE) begin
                        st_phase = SQ_SEND_IMG;
                        // no finger burns two polls of the placement budget
                        if (cls == CLS_NO_FINGER) begin
                            void'(tick_wait());
                            if (tick_wait())
                                fail_enroll(CAUSE_TIMEOUT);
                        end
                    end else begin
                        fail_enroll(CAUSE_ENROLL);
                    end
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            SQ_SEND_GEN: begin
                st_phase     = SQ_WAIT_GEN;
                r.module_cmd = MCMD_GEN;
                r.cmd_arg    = 16'(st_caps);
                st_wait      = cf_reply;
            end
            SQ_WAIT_GEN: begin
                if (p.reply_seen) begin
                    if (cls == CLS_OK) begin
                        if (st_caps == 4'd1 && st_dup) begin
                            if (st_caps != 4'hF)
                                st_caps++;
                            st_phase = SQ_SEND_SEARCH;
                            st_dup   = 1'b0;
                            st_wait  = cf_reply;
                        end else if (st_caps < cf_caps) begin
                            st_phase = SQ_SEND_LIFT;
                            st_wait  = cf_lift;
                            if (st_caps != 4'hF)
                                st_caps++;
                            r.prompt = PROMPT_AGAIN;
                        end else begin
                            st_phase = SQ_SEND_MERGE;
                            st_wait  = cf_reply;
                        end
                        r.wake = 1'b1;
                    end else if (cls == CLS_FEATURE_FAIL || cls == CLS_CAPTURE_FAIL) begin
                        if (st_fails < cf_retry) begin
                            st_phase = SQ_SEND_LIFT;
                            st_wait  = cf_lift;
                            r.wake   = 1'b1;
                            r.prompt = PROMPT_AGAIN;
                        end else begin
                            fail_enroll(CAUSE_ENROLL);
                        end
                        if (st_fails != 4'hF)
                            st_fails++;
                    end else begin
                        fail_enroll(CAUSE_ENROLL);
                    end
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            SQ_SEND_SEARCH: begin
                st_phase     = SQ_WAIT_SEARCH;
                r.module_cmd = MCMD_SEARCH;
                r.cmd_arg    = cf_pages;
            end
            SQ_WAIT_SEARCH: begin
                if (p.reply_seen) begin
                    if (cls == CLS_OK) begin
                        fail_enroll(CAUSE_DUPLICATE);
                    end else if (cls == CLS_NOT_FOUND) begin
                        st_phase = SQ_SEND_LIFT;
                        st_wait  = cf_lift;
                        r.wake   = 1'b1;
                        r.prompt = PROMPT_AGAIN;
                    end else begin
                        fail_enroll(CAUSE_ENROLL);
                    end
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            SQ_SEND_LIFT: begin
                st_phase     = SQ_WAIT_LIFT;
                r.module_cmd = MCMD_CAPTURE;
            end
            SQ_WAIT_LIFT: begin
                if (p.reply_seen) begin
                    if (cls != CLS_NO_FINGER) begin
                        st_phase = SQ_SEND_LIFT;
                        r.wake   = 1'b1;
                    end else begin
                        st_phase = SQ_SEND_IMG;
                        st_wait  = cf_put;
                    end
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            SQ_SEND_MERGE: begin
                st_phase     = SQ_WAIT_MERGE;
                r.module_cmd = MCMD_MERGE;
                st_wait      = cf_reply;
            end
            SQ_WAIT_MERGE: begin
                if (p.reply_seen) begin
                    if (cls == CLS_OK)
                        st_phase = SQ_SEND_STORE;
                    else
                        fail_enroll(CAUSE_ENROLL);
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            SQ_SEND_STORE: begin
                st_phase     = SQ_WAIT_STORE;
                r.module_cmd = MCMD_STORE;
                r.cmd_arg    = p.user_slot;
                st_wait      = cf_reply;
            end
            SQ_WAIT_STORE: begin
                if (p.reply_seen) begin
                    if (cls == CLS_OK)
                        st_phase = SQ_DONE;
                    else
                        fail_enroll(CAUSE_ENROLL);
                end else if (tick_wait()) begin
                    fail_enroll(CAUSE_TIMEOUT);
                end
            end
            default: ;
        endcase
        r.phase      = (st_phase == SQ_DONE)   ? OUT_ENROLLED :
                       (st_phase == SQ_FAILED) ? OUT_FAILED : OUT_BUSY;
        r.fail_cause = (st_phase == SQ_FAILED) ? st_cause : CAUSE_NONE;
        return r;
    endfunction

    function automatic fes_in_t mk_poll(logic cmd, logic seen, logic [2:0] cls,
                                        logic [15:0] slot);
        fes_in_t p;
        p.cmd         = cmd;
        p.reply_seen  = seen;
        p.reply_class = cls;
        p.user_slot   = slot;
        return p;
    endfunction

    // Present one poll after a random gap, hold it until the transfer, then
    // queue its predicted report. Valid stays high on exit so back-to-back
    // polls stream; settle() drops it.
    task automatic send_poll(fes_in_t p);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        poll_reports_due.push_back(enroll_step(p));
    endtask

    // Drop valid and wait until every predicted report has transferred.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (poll_reports_due.size() != 0)
            @(posedge aclk);
    endtask

    // Hold one register write until it transfers; valid stays high for the next.
    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, d);
    endtask

    // Write every register while the sequencer is idle, plus the unused index.
    task automatic load_config(logic [15:0] put, logic [15:0] lift, logic [15:0] reply,
                               logic [15:0] caps, logic [15:0] retry, logic [15:0] dup,
                               logic [15:0] pages);
        write_reg(CFG_PUT_FINGER_TIMEOUT, put);
        write_reg(CFG_REMOVE_FINGER_TIMEOUT, lift);
        write_reg(CFG_REPLY_TIMEOUT, reply);
        write_reg(CFG_ENROLL_CAPTURES, caps);
        write_reg(CFG_RETRY_LIMIT, retry);
        write_reg(CFG_DUPLICATE_CHECK, dup);
        write_reg(CFG_LIBRARY_PAGES, pages);
        write_reg(CFG_UNUSED, 16'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short budgets so timeouts fire, now and then zero or the maximum.
    function automatic logic [15:0] pick_timeout();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(12));
        else if (roll < 90)
            return 16'($urandom_range(300, 13));
        return 16'hFFFF;
    endfunction

    // Choose the next poll from the predicted phase: mostly the reply that
    // moves the enrollment forward, with random content, aborts and noise.
    function automatic fes_in_t pick_poll();
        fes_in_t p;
        int      roll;
        p.cmd         = CMD_POLL;
        p.reply_seen  = ($urandom_range(99) < 75);
        p.reply_class = 3'($urandom_range(7));
        p.user_slot   = 16'($urandom);
        if ($urandom_range(9) == 0)
            p.user_slot = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        roll = $urandom_range(99);
        if (roll < 6) begin
            p.cmd = 1'($urandom_range(1));
            return p;
        end
        if (st_phase == SQ_DONE || st_phase == SQ_FAILED) begin
            p.cmd = ($urandom_range(99) < 85) ? CMD_RESTART : CMD_POLL;
            return p;
        end
        if (roll < 8) begin
            p.cmd = CMD_RESTART;
            return p;
        end
        if ($urandom_range(99) < 80) begin
            case (st_phase)
                SQ_WAIT_IMG:    p.reply_class = CLS_OK;
                SQ_WAIT_GEN:    p.reply_class = ($urandom_range(3) == 0) ?
                                                CLS_FEATURE_FAIL : CLS_OK;
                SQ_WAIT_SEARCH: p.reply_class = ($urandom_range(4) == 0) ?
                                                CLS_OK : CLS_NOT_FOUND;
                SQ_WAIT_LIFT:   p.reply_class = ($urandom_range(9) < 7) ?
                                                CLS_NO_FINGER : CLS_OK;
                SQ_WAIT_MERGE:  p.reply_class = CLS_OK;
                SQ_WAIT_STORE:  p.reply_class = CLS_OK;
                default: ;
            endcase
        end
        return p;
    endfunction

    // Shortest success path: one capture, no search; replies on send polls
    // must be ignored, and a finished sequencer repeats its outcome.
    task automatic test_single_capture_enroll();
        settle();
        load_config(16'd5, 16'd5, 16'd5, 16'd1, 16'd0, 16'd0, 16'd7);
        send_poll(mk_poll(CMD_RESTART, 1'b1, CLS_OTHER, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_FEATURE_FAIL, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_SEVEN, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'hFFFF));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
    endtask

    // Search after the first feature finds a match: already registered.
    task automatic test_duplicate_rejected();
        settle();
        load_config(16'd9, 16'd9, 16'd9, 16'd2, 16'd1, 16'd1, 16'hFFFF);
        send_poll(mk_poll(CMD_RESTART, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_NOT_FOUND, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
    endtask

    // Zero budgets: a silent poll fails at once, and so does a no-finger
    // reply; restart must clear the held cause.
    task automatic test_zero_timeouts();
        settle();
        load_config(16'd0, 16'd1, 16'd0, 16'd15, 16'd15, 16'd1, 16'd1);
        send_poll(mk_poll(CMD_RESTART, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_RESTART, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b0, CLS_OK, 16'h0000));
        send_poll(mk_poll(CMD_POLL, 1'b1, CLS_NO_FINGER, 16'h0000));
    endtask

    // Random enrollments under each idle profile, with a fresh set of
    // registers per round; the first rounds take low values and the maxima.
    task automatic test_random_enrollments();
        fes_in_t p;
        int      polls;
        for (int prof = 0; prof < 3; prof++) begin
            case (prof)
                0: begin snd_idle_pct = 34; rcv_idle_pct = 79; end
                1: begin snd_idle_pct = 79; rcv_idle_pct = 34; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int round = 0; round < 4; round++) begin
                settle();
                if (prof == 0 && round == 0)
                    load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
                else if (prof == 1 && round == 0)
                    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF);
                else
                    load_config(pick_timeout(), pick_timeout(), pick_timeout(),
                                {12'($urandom), 4'($urandom_range(15))},
                                {12'($urandom), 4'($urandom_range(15))},
                                16'($urandom),
                                $urandom_range(3) == 0 ? 16'($urandom_range(1)) :
                                                         16'($urandom));
                polls = 0;
                while (polls < 96) begin
                    p = pick_poll();
                    // polls into a finished sequencer only repeat its outcome
                    if (!((st_phase == SQ_DONE || st_phase == SQ_FAILED) &&
                          p.cmd == CMD_POLL))
                        polls++;
                    send_poll(p);
                end
            end
        end
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PUT_FINGER_TIMEOUT;
        cfg_data     = '0;
        mismatches   = 0;
        cycle_count  = 0;
        snd_idle_pct = 34;
        rcv_idle_pct = 79;
        reset_model();

        // hold reset low, then release it between edges
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_capture_enroll();
        test_duplicate_rejected();
        test_zero_timeouts();
        test_random_enrollments();

        // drain, then give the result register time to show strays
        settle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ fingerprint_enroll_sequencer.f @@
+incdir+rtl
rtl/fes_pkg.sv
rtl/fes_cfg_regs.sv
rtl/fes_seq_core.sv
rtl/fingerprint_enroll_sequencer.sv
tb/tb_fingerprint_enroll_sequencer.sv
